FILE: sv/assert_macros.svh
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising clock edge, off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication with an overlapping consequent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

// implication whose consequent is checked on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

FILE: sv/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, widths and helpers of the pending request timeout table.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

	// table size and derived widths
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int PTR_W       = CNT_W + 1;

	// fixed field widths
	localparam int FUNC_W   = 3;
	localparam int KEY_W    = 64;
	localparam int STAMP_W  = 64;
	localparam int HANDLE_W = 32;
	localparam int INDEX_W  = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;
	localparam logic [63:0] TIMEOUT_RESET = 64'd10000000;

	// register index, taken from the top address bit
	typedef enum logic [0:0] {
		REG_TIMEOUT = 1'b0
	} reg_idx_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_START  = 3'd0,
		FN_END    = 3'd1,
		FN_CHECK  = 3'd2,
		FN_PAUSE  = 3'd3,
		FN_RESUME = 3'd4,
		FN_CLEAR  = 3'd5,
		FN_READ   = 3'd6
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_SHIFT,
		S_CHK,
		S_RDW,
		S_DONE
	} fsm_t;

	// one table entry as stored in the memory
	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [STAMP_W-1:0]  stamp;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// memory write request
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} mem_wr_t;

	// occupancy shown on the count field
	function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] occ);
		logic [CNT_W+COUNT_W-1:0] ext;
		ext = {{COUNT_W{1'b0}}, occ};
		return ext[COUNT_W-1:0];
	endfunction

	// read position lies below the occupancy
	function automatic logic index_valid(input logic [INDEX_W-1:0] idx,
			input logic [CNT_W-1:0] occ);
		logic [CNT_W+INDEX_W-1:0] a;
		logic [CNT_W+INDEX_W-1:0] b;
		a = {{CNT_W{1'b0}}, idx};
		b = {{INDEX_W{1'b0}}, occ};
		return a < b;
	endfunction

endpackage

`default_nettype wire

FILE: sv/ptt_if.sv
// ----------------------------------------------------------------------------
// ptt_if
// Request and response channels of the pending request timeout table.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptt_req_if;
	import ptt_pkg::*;

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [KEY_W-1:0]    key;
	logic [HANDLE_W-1:0] handle;
	logic [STAMP_W-1:0]  now;
	logic [INDEX_W-1:0]  index;

	modport source(output valid, func, key, handle, now, index, input ready);
	modport sink(input valid, func, key, handle, now, index, output ready);
endinterface

interface ptt_rsp_if;
	import ptt_pkg::*;

	logic                valid;
	logic                ready;
	logic                expired;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count;
	logic [KEY_W-1:0]    entry_key;
	logic [STAMP_W-1:0]  entry_time;
	logic [HANDLE_W-1:0] entry_handle;

	modport source(output valid, expired, status, count, entry_key, entry_time,
		entry_handle, input ready);
	modport sink(input valid, expired, status, count, entry_key, entry_time,
		entry_handle, output ready);
endinterface

`default_nettype wire

FILE: sv/ptt_ram.sv
// ----------------------------------------------------------------------------
// ptt_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered output
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: sv/ptt_cfg.sv
// ----------------------------------------------------------------------------
// ptt_cfg
// APB register slave holding the expiry timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [ptt_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [ptt_pkg::PDATA_W-1:0]  pwdata,
	output logic      [ptt_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	output logic      [ptt_pkg::STAMP_W-1:0]  timeout
);
	import ptt_pkg::*;

	logic [STAMP_W-1:0] timeout_q;
	reg_idx_t           reg_sel;
	logic               sel_timeout;

	// register decode on the top address bit
	assign reg_sel     = reg_idx_t'(paddr[PADDR_W-1]);
	assign sel_timeout = (reg_sel == REG_TIMEOUT);

	// register write in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && sel_timeout) begin
			timeout_q <= pwdata;
		end
	end

	// read back
	assign prdata  = sel_timeout ? timeout_q : '0;
	assign pready  = 1'b1;
	assign timeout = timeout_q;

endmodule

`default_nettype wire

FILE: sv/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer that executes one table operation at a time against the
// entry memory: append, key search with gap closing, expiry check, read.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	ptt_req_if.sink                           req,
	ptt_rsp_if.source                         rsp,
	input  wire logic [ptt_pkg::STAMP_W-1:0]  timeout,
	output ptt_pkg::mem_wr_t                  mem_wr,
	output logic      [ptt_pkg::IDX_W-1:0]    mem_raddr,
	input  wire logic [ptt_pkg::ENTRY_W-1:0]  mem_rdata
);
	import ptt_pkg::*;

	fsm_t state_q, state_d;

	// control state
	logic [CNT_W-1:0] occ_q;
	logic             paused_q;
	logic [PTR_W-1:0] ptr_q;
	logic             out_valid_q;

	// latched transaction
	func_t               func_q;
	logic [KEY_W-1:0]    key_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [STAMP_W-1:0]  now_q;
	logic [INDEX_W-1:0]  index_q;

	// result under construction and output register
	logic                res_exp_q;
	status_t             res_status_q;
	entry_t              res_entry_q;
	logic                out_exp_q;
	status_t             out_status_q;
	logic [COUNT_W-1:0]  out_count_q;
	entry_t              out_entry_q;

	entry_t             rd_entry;
	logic [PTR_W-1:0]   occ_ext;
	logic [PTR_W-1:0]   ptr_next;
	logic [PTR_W-1:0]   ptr_next2;
	logic               more1;
	logic               more2;
	logic               full;
	logic               empty;
	logic               hit;
	logic               in_range;
	logic [STAMP_W-1:0] elapsed;
	logic               is_exp;
	logic               out_free;

	// helpers shared by the sequencer
	assign rd_entry  = entry_t'(mem_rdata);
	assign occ_ext   = {1'b0, occ_q};
	assign ptr_next  = ptr_q + PTR_W'(1);
	assign ptr_next2 = ptr_q + PTR_W'(2);
	assign more1     = (ptr_next < occ_ext);
	assign more2     = (ptr_next2 < occ_ext);
	assign full      = (occ_q == CNT_W'(TABLE_DEPTH));
	assign empty     = (occ_q == '0);
	assign hit       = (rd_entry.key == key_q);
	assign in_range  = index_valid(index_q, occ_q);
	assign elapsed   = now_q - rd_entry.stamp;
	assign is_exp    = (elapsed >= timeout);
	assign out_free  = !out_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (func_q)
					FN_END:   state_d = empty ? S_DONE : S_SCAN;
					FN_CHECK: state_d = (paused_q || empty) ? S_DONE : S_CHK;
					FN_READ:  state_d = in_range ? S_RDW : S_DONE;
					default:  state_d = S_DONE;
				endcase
			end
			S_SCAN: begin
				if (hit) begin
					state_d = more1 ? S_SHIFT : S_DONE;
				end else begin
					state_d = more1 ? S_SCAN : S_DONE;
				end
			end
			S_SHIFT: begin
				state_d = more2 ? S_SHIFT : S_DONE;
			end
			S_CHK:  state_d = S_DONE;
			S_RDW:  state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory accesses and handshake outputs
	always_comb begin
		req.ready   = (state_q == S_IDLE);
		mem_wr.we   = 1'b0;
		mem_wr.addr = ptr_q[IDX_W-1:0];
		mem_wr.data = rd_entry;
		mem_raddr   = ptr_q[IDX_W-1:0];
		case (state_q)
			S_EXEC: begin
				case (func_q)
					FN_START: begin
						mem_wr.we   = !full;
						mem_wr.addr = occ_q[IDX_W-1:0];
						mem_wr.data = '{key: key_q, stamp: now_q, handle: handle_q};
					end
					FN_READ:  mem_raddr = index_q[IDX_W-1:0];
					default:  mem_raddr = '0;
				endcase
			end
			S_SCAN: begin
				mem_raddr = ptr_next[IDX_W-1:0];
			end
			S_SHIFT: begin
				// move entry ptr+1 down into the gap, fetch the one after it
				mem_wr.we = 1'b1;
				mem_raddr = ptr_next2[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			paused_q    <= 1'b0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// output register fills from the done state, empties on acceptance
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					ptr_q <= '0;
				end
				S_EXEC: begin
					case (func_q)
						FN_START:  if (!full) occ_q <= occ_q + CNT_W'(1);
						FN_PAUSE:  paused_q <= 1'b1;
						FN_RESUME: paused_q <= 1'b0;
						FN_CLEAR:  occ_q <= '0;
						default: ;
					endcase
				end
				S_SCAN: begin
					if (hit) begin
						if (!more1) occ_q <= occ_q - CNT_W'(1);
					end else if (more1) begin
						ptr_q <= ptr_next;
					end
				end
				S_SHIFT: begin
					if (more2) begin
						ptr_q <= ptr_next;
					end else begin
						occ_q <= occ_q - CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// transaction, result and output payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					func_q   <= func_t'(req.func);
					key_q    <= req.key;
					handle_q <= req.handle;
					now_q    <= req.now;
					index_q  <= req.index;
				end
			end
			S_EXEC: begin
				res_exp_q   <= 1'b0;
				res_entry_q <= '0;
				case (func_q)
					FN_START: res_status_q <= full ? ST_FULL : ST_OK;
					FN_END:   res_status_q <= empty ? ST_MISSING : ST_OK;
					FN_READ:  res_status_q <= in_range ? ST_OK : ST_RANGE;
					default:  res_status_q <= ST_OK;
				endcase
			end
			S_SCAN: begin
				if (!hit && !more1) res_status_q <= ST_MISSING;
			end
			S_CHK: begin
				res_exp_q <= is_exp;
			end
			S_RDW: begin
				res_entry_q <= rd_entry;
			end
			S_DONE: begin
				if (out_free) begin
					out_exp_q    <= res_exp_q;
					out_status_q <= res_status_q;
					out_count_q  <= to_count(occ_q);
					out_entry_q  <= res_entry_q;
				end
			end
			default: ;
		endcase
	end

	// response channel
	assign rsp.valid        = out_valid_q;
	assign rsp.expired      = out_exp_q;
	assign rsp.status       = out_status_q;
	assign rsp.count        = out_count_q;
	assign rsp.entry_key    = out_entry_q.key;
	assign rsp.entry_time   = out_entry_q.stamp;
	assign rsp.entry_handle = out_entry_q.handle;

endmodule

`default_nettype wire

FILE: sv/pending_request_timeout_table_unit.sv
// ----------------------------------------------------------------------------
// pending_request_timeout_table_unit
// Ordered table of pending requests with start, end, expiry check and read.
// ----------------------------------------------------------------------------
// Usage:
// - req carries one operation per transaction (func, key, handle, now, index);
//   rsp returns exactly one result per operation, in order.
// - The expiry timeout is a 64-bit register at byte address 0 of the APB port,
//   written while no operation is in flight; pready is always high.
// - Entries live in one 160-bit by 16 memory with a registered read port.
// - Each operation runs through an execute state and a done state before its
//   result enters the output register. Any check that is not paused or on an
//   empty table, and a read in range, add one memory read state between them;
//   end on a non-empty table scans entries one per cycle up to the match and
//   then moves each later entry down one slot per cycle through the single
//   entry memory.
// - One operation is in flight at a time; a new one is accepted in the cycle
//   after its predecessor's result enters the output register.
// - Reset empties the table, clears the paused flag and loads the timeout
//   with 10000000; memory contents are left as they are.
// - When rsp stalls, the result holds in the output register; one further
//   operation is accepted and executed, then waits for the register to free.
// ----------------------------------------------------------------------------
`default_nettype none

module pending_request_timeout_table_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	ptt_req_if.sink                           req,
	ptt_rsp_if.source                         rsp,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [ptt_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [ptt_pkg::PDATA_W-1:0]  pwdata,
	output logic      [ptt_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready
);
	import ptt_pkg::*;

	logic [STAMP_W-1:0] timeout;
	mem_wr_t            mem_wr;
	logic [IDX_W-1:0]   mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;

	// configuration register
	ptt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.timeout (timeout)
	);

	// operation sequencer
	ptt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.timeout   (timeout),
		.mem_wr    (mem_wr),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// entry memory
	ptt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_wr.we),
		.waddr (mem_wr.addr),
		.wdata (mem_wr.data),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

FILE: sv/ptt_checker.sv
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks of the pending request timeout table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptt_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic                          expired,
	input wire logic [ptt_pkg::STATUS_W-1:0]  status,
	input wire logic [ptt_pkg::COUNT_W-1:0]   count,
	input wire logic [ptt_pkg::KEY_W-1:0]     entry_key,
	input wire logic [ptt_pkg::STAMP_W-1:0]   entry_time,
	input wire logic [ptt_pkg::HANDLE_W-1:0]  entry_handle
);
	import ptt_pkg::*;

	logic no_entry;

	assign no_entry = (entry_key == '0) && (entry_time == '0) && (entry_handle == '0);

	// a stalled result holds
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(count) && $stable(entry_key), "stalled result changed")

	// a dropped start leaves a full table
	`ASSERT_IMPL(a_full_count, clk, arst_n, rsp_valid && (status == ST_FULL), count == COUNT_W'(TABLE_DEPTH), "full status with table not full")

	// expiry only on a clean result with no entry data
	`ASSERT_IMPL(a_exp_clean, clk, arst_n, rsp_valid && expired, (status == ST_OK) && no_entry && (count != '0), "expired with inconsistent fields")

	// out of range read returns no entry
	`ASSERT_IMPL(a_range_zero, clk, arst_n, rsp_valid && (status == ST_RANGE), no_entry && !expired, "range error with entry data")

endmodule

bind pending_request_timeout_table_unit ptt_checker u_ptt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.expired      (rsp.expired),
	.status       (rsp.status),
	.count        (rsp.count),
	.entry_key    (rsp.entry_key),
	.entry_time   (rsp.entry_time),
	.entry_handle (rsp.entry_handle)
);

`default_nettype wire

FILE: tb/timeout_table_monitor.sv
// ----------------------------------------------------------------------------
// timeout_table_monitor
// Watches the operation, result and register ports of the pending request
// timeout table. It keeps its own copy of the table, works out the result of
// each accepted operation and compares it with the returned transaction.
// ----------------------------------------------------------------------------
module timeout_table_monitor (
	input  logic                         clk,
	input  logic                         arst_n,
	ptt_req_if                           req,
	ptt_rsp_if                           rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [ptt_pkg::PADDR_W-1:0]  paddr,
	input  logic [ptt_pkg::PDATA_W-1:0]  pwdata,
	output int                           mismatches,
	output int                           awaiting
);
	import ptt_pkg::*;

	typedef struct packed {
		logic                expired;
		status_t             status;
		logic [COUNT_W-1:0]  count;
		logic [KEY_W-1:0]    key;
		logic [STAMP_W-1:0]  stamp;
		logic [HANDLE_W-1:0] handle;
	} table_result_t;

	// shadow copy of the table
	logic [KEY_W-1:0]    key_mem    [TABLE_DEPTH];
	logic [STAMP_W-1:0]  stamp_mem  [TABLE_DEPTH];
	logic [HANDLE_W-1:0] handle_mem [TABLE_DEPTH];
	int                  occupancy;
	bit                  paused;
	logic [63:0]         expiry_timeout;

	table_result_t pending_results[$];
	table_result_t want;

	// apply one operation to the shadow table and return its result
	function automatic table_result_t run_operation(input logic [FUNC_W-1:0] f,
			input logic [KEY_W-1:0] k, input logic [HANDLE_W-1:0] h,
			input logic [STAMP_W-1:0] now, input logic [INDEX_W-1:0] ix);
		table_result_t res;
		bit found;
		logic [STAMP_W-1:0] elapsed;
		res = '0;
		res.status = ST_OK;
		found = 1'b0;
		case (f)
			FN_START: begin
				if (occupancy >= TABLE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					key_mem[occupancy] = k;
					stamp_mem[occupancy] = now;
					handle_mem[occupancy] = h;
					occupancy++;
				end
			end
			FN_END: begin
				// first match goes, later entries move down one slot
				for (int pos = 0; pos < occupancy; pos++) begin
					if (!found && key_mem[pos] == k)
						found = 1'b1;
					if (found && pos + 1 < occupancy) begin
						key_mem[pos] = key_mem[pos + 1];
						stamp_mem[pos] = stamp_mem[pos + 1];
						handle_mem[pos] = handle_mem[pos + 1];
					end
				end
				if (found)
					occupancy--;
				else
					res.status = ST_MISSING;
			end
			FN_CHECK: begin
				// elapsed time wraps modulo 2^64
				elapsed = now - stamp_mem[0];
				if (!paused && occupancy > 0 && elapsed >= expiry_timeout)
					res.expired = 1'b1;
			end
			FN_PAUSE: paused = 1'b1;
			FN_RESUME: paused = 1'b0;
			FN_CLEAR: occupancy = 0;
			FN_READ: begin
				if (int'(ix) < occupancy) begin
					res.key = key_mem[ix];
					res.stamp = stamp_mem[ix];
					res.handle = handle_mem[ix];
				end else begin
					res.status = ST_RANGE;
				end
			end
			default: ;
		endcase
		res.count = occupancy[COUNT_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupancy = 0;
			paused = 1'b0;
			mismatches = 0;
			expiry_timeout = TIMEOUT_RESET;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				key_mem[i] = '0;
				stamp_mem[i] = '0;
				handle_mem[i] = '0;
			end
			pending_results.delete();
		end else begin
			// compare a returned transaction with the oldest prediction
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					$error("result with nothing expected: status %0d count %0d",
						rsp.status, rsp.count);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (rsp.expired !== want.expired) begin
						$error("expired: expected %0d, got %0d", want.expired, rsp.expired);
						mismatches++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatches++;
					end
					if (rsp.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, rsp.count);
						mismatches++;
					end
					if (rsp.entry_key !== want.key) begin
						$error("entry_key: expected %h, got %h", want.key, rsp.entry_key);
						mismatches++;
					end
					if (rsp.entry_time !== want.stamp) begin
						$error("entry_time: expected %h, got %h", want.stamp,
							rsp.entry_time);
						mismatches++;
					end
					if (rsp.entry_handle !== want.handle) begin
						$error("entry_handle: expected %h, got %h", want.handle,
							rsp.entry_handle);
						mismatches++;
					end
				end
			end
			// predict each accepted operation
			if (req.valid && req.ready)
				pending_results.insert(pending_results.size(),
					run_operation(req.func, req.key, req.handle, req.now, req.index));
			// register write on the access cycle
			if (psel && penable && pwrite && pready &&
					reg_idx_t'(paddr[PADDR_W-1]) == REG_TIMEOUT)
				expiry_timeout = pwdata;
		end
		awaiting = pending_results.size();
	end

endmodule

FILE: tb/tb_pending_request_timeout_table_unit.sv
// ----------------------------------------------------------------------------
// tb_pending_request_timeout_table_unit
// Drives operations into the pending request timeout table: a directed run
// over the corner cases, then random start/end traffic with checks, reads,
// pauses and clears under several expiry timeouts, with random stalls on both
// channels. Results are predicted and compared by timeout_table_monitor.
// ----------------------------------------------------------------------------
module tb_pending_request_timeout_table_unit;
	import ptt_pkg::*;

	localparam logic [FUNC_W-1:0]   FN_UNUSED    = 3'd7;
	localparam logic [PADDR_W-1:0]  TIMEOUT_ADDR = {REG_TIMEOUT, {(PADDR_W-1){1'b0}}};
	localparam logic [63:0]         ALL_ONES     = {64{1'b1}};
	localparam logic [HANDLE_W-1:0] HANDLE_ONES  = {HANDLE_W{1'b1}};
	localparam int                  SETTINGS_N   = 5;
	localparam int                  OPS_PER_SETTING = 120;
	localparam int                  SETTLE_CYCLES = 40;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int          mismatches;
	int          awaiting;
	int          sent;
	int          phase;
	int          op_no;
	bit          calm;
	logic [63:0] clock_now;
	logic [63:0] expiry_now;
	logic [63:0] key_pool[$];
	logic [63:0] timeout_plan[SETTINGS_N];

	ptt_req_if req_ch ();
	ptt_rsp_if rsp_ch ();

	pending_request_timeout_table_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	timeout_table_monitor mon (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.mismatches(mismatches),
		.awaiting(awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("run stopped: transactions no longer moving");
		$display("Mismatches found");
		$finish;
	end

	// result side stalls at random unless in a calm stretch
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 24);
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// one operation transaction, with an optional random gap first
	task automatic send(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
			input logic [HANDLE_W-1:0] h, input logic [STAMP_W-1:0] t,
			input logic [INDEX_W-1:0] ix);
		if (!calm && $urandom_range(0, 99) < 24) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 24);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.key <= k;
		req_ch.handle <= h;
		req_ch.now <= t;
		req_ch.index <= ix;
		do @(posedge clk); while (!req_ch.ready);
		sent++;
	endtask

	// stop sending until every result is back
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
	endtask

	task automatic write_timeout(input logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= TIMEOUT_ADDR;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		expiry_now = v;
	endtask

	// random operation; end keys mostly reuse earlier keys, start keys sometimes
	task automatic random_op(input int start_pct, input int end_pct);
		int r;
		logic [FUNC_W-1:0] f;
		logic [KEY_W-1:0] k;
		logic [STAMP_W-1:0] t;
		logic [INDEX_W-1:0] ix;
		r = $urandom_range(0, 99);
		k = rand64();
		if (r < start_pct) begin
			f = FN_START;
			if (key_pool.size() != 0 && $urandom_range(0, 99) < 25)
				k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			key_pool.insert(key_pool.size(), k);
			if (key_pool.size() > 24)
				key_pool.delete(0);
		end else if (r < start_pct + end_pct) begin
			f = FN_END;
			if (key_pool.size() != 0 && $urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, key_pool.size() - 1)];
		end else begin
			r = $urandom_range(0, 99);
			if (r < 40)
				f = FN_CHECK;
			else if (r < 70)
				f = FN_READ;
			else if (r < 80)
				f = FN_PAUSE;
			else if (r < 90)
				f = FN_RESUME;
			else if (r < 96)
				f = FN_CLEAR;
			else
				f = FN_UNUSED;
		end
		// time moves in steps scaled to the timeout, sometimes jumps anywhere
		clock_now += rand64() % ((expiry_now >> 1) + 64'd2);
		t = ($urandom_range(0, 99) < 15) ? rand64() : clock_now;
		ix = INDEX_W'($urandom_range(0, 15));
		send(f, k, $urandom, t, ix);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.func = FN_START;
		req_ch.key = '0;
		req_ch.handle = '0;
		req_ch.now = '0;
		req_ch.index = '0;
		calm = 1'b0;
		sent = 0;
		clock_now = '0;
		expiry_now = TIMEOUT_RESET;
		timeout_plan[0] = 64'd1;
		timeout_plan[1] = ALL_ONES;
		timeout_plan[2] = 64'd1000;
		timeout_plan[3] = rand64() | 64'd1;
		timeout_plan[4] = TIMEOUT_RESET;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, duplicates, pause, wrap, clear
		send(FN_READ, '0, '0, '0, 4'd0);
		send(FN_CHECK, '0, '0, '0, '0);
		send(FN_END, 64'd5, '0, '0, '0);
		send(FN_START, '0, '0, '0, '0);
		send(FN_START, ALL_ONES, HANDLE_ONES, ALL_ONES, ALL_ONES[INDEX_W-1:0]);
		send(FN_START, '0, 32'h1234_5678, 64'd5, '0);
		send(FN_READ, '0, '0, '0, 4'd0);
		send(FN_READ, '0, '0, '0, 4'd2);
		send(FN_READ, '0, '0, '0, 4'd15);
		send(FN_CHECK, '0, '0, TIMEOUT_RESET - 64'd1, '0);
		send(FN_CHECK, '0, '0, TIMEOUT_RESET, '0);
		send(FN_PAUSE, '0, '0, '0, '0);
		send(FN_PAUSE, '0, '0, '0, '0);
		send(FN_CHECK, '0, '0, TIMEOUT_RESET, '0);
		send(FN_RESUME, '0, '0, '0, '0);
		send(FN_RESUME, '0, '0, '0, '0);
		send(FN_END, '0, '0, '0, '0);
		send(FN_READ, '0, '0, '0, 4'd1);
		// oldest stamp is all ones now, so the difference wraps
		send(FN_CHECK, '0, '0, TIMEOUT_RESET - 64'd2, '0);
		send(FN_CHECK, '0, '0, TIMEOUT_RESET - 64'd1, '0);
		send(FN_UNUSED, ALL_ONES, HANDLE_ONES, ALL_ONES, ALL_ONES[INDEX_W-1:0]);
		send(FN_CLEAR, '0, '0, '0, '0);
		send(FN_READ, '0, '0, '0, 4'd0);

		// random traffic under each timeout, filling and draining phases
		for (phase = 0; phase < SETTINGS_N; phase++) begin
			drain();
			write_timeout(timeout_plan[phase]);
			calm = (phase == 2);
			for (op_no = 0; op_no < OPS_PER_SETTING; op_no++) begin
				if (phase == 1 && op_no == OPS_PER_SETTING / 2)
					drain();
				if (phase % 2 == 0)
					random_op(55, 15);
				else
					random_op(30, 35);
			end
		end
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (awaiting != 0)
			$error("%0d results never arrived", awaiting);
		$display("%0d operations sent: directed corner cases, then random traffic", sent);
		$display("under the reset timeout and %0d written ones incl. 1 and all ones",
			SETTINGS_N);
		if (mismatches == 0 && awaiting == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
